// ===== design/sal_pkg.sv =====
// Package for the sorted array list unit: field widths, action and status codes,
// and the control struct that the sequencer hands to the cell row.
// No dependencies.
package sal_pkg;

   // Fixed widths of the item and result fields
   localparam int ACTION_W = 3;
   localparam int VALUE_W  = 32;
   localparam int STATUS_W = 2;
   localparam int ITEM_W   = 32;
   localparam int LENGTH_W = 5;

   // Action codes
   localparam logic [ACTION_W-1:0] ACT_INSERT   = 3'd0;
   localparam logic [ACTION_W-1:0] ACT_DELETE   = 3'd1;
   localparam logic [ACTION_W-1:0] ACT_SEARCH   = 3'd2;
   localparam logic [ACTION_W-1:0] ACT_GET_NEXT = 3'd3;
   localparam logic [ACTION_W-1:0] ACT_REWIND   = 3'd4;
   localparam logic [ACTION_W-1:0] ACT_CLEAR    = 3'd5;

   // Status codes
   localparam logic [STATUS_W-1:0] STS_OK        = 2'd0;
   localparam logic [STATUS_W-1:0] STS_FULL      = 2'd1;
   localparam logic [STATUS_W-1:0] STS_NOT_FOUND = 2'd2;
   localparam logic [STATUS_W-1:0] STS_EMPTY     = 2'd3;

   // Per-cycle commands to every cell of the row
   typedef struct packed {
      logic do_compare;
      logic do_insert;
      logic do_remove;
   } cell_ctl_type;

endpackage

// ===== design/sorted_array_list_unit.sv =====
// Top level of the sorted array list unit: sequencer, length and cursor, result registers.
// Depends on sal_pkg and sal_chain.
//
// Keeps up to CAPACITY values in ascending order in a row of cells, one entry per cell.
// An item is taken when start is high and busy is low. Every item goes through
// the accept cycle, a compare pass in which every cell checks its entry against the
// operand and its index against the cursor, and an update pass in which the cells
// shift in parallel (right on insert, left on delete) while the result is registered.
// The result shows for one cycle on rsp_valid in the cycle after the update pass, and
// that same cycle can already accept the next item. Busy stays high through both passes
// over the cell row. Results cannot be held off by the receiver.
// Entries are valid only below the current length; nothing needs clearing after reset.
module sorted_array_list_unit #(
   parameter int CAPACITY   = 16,
   parameter int DATA_WIDTH = 32
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   output logic                          busy,
   input  logic [sal_pkg::ACTION_W-1:0]  req_action,
   input  logic [sal_pkg::VALUE_W-1:0]   req_value,
   output logic                          rsp_valid,
   output logic [sal_pkg::STATUS_W-1:0]  rsp_status,
   output logic                          rsp_found,
   output logic [sal_pkg::ITEM_W-1:0]    rsp_item,
   output logic [sal_pkg::LENGTH_W-1:0]  rsp_length,
   output logic                          rsp_full_res,
   output logic                          rsp_empty_res
);
   import sal_pkg::*;

   localparam int CNT_W = $clog2(CAPACITY + 1);
   localparam int VW    = (DATA_WIDTH < VALUE_W) ? DATA_WIDTH : VALUE_W;
   localparam int IW    = (DATA_WIDTH < ITEM_W) ? DATA_WIDTH : ITEM_W;
   localparam logic [CNT_W-1:0] CAP_CNT = CNT_W'(CAPACITY);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_COMPARE,
      ST_UPDATE
   } state_type;

   state_type             state_ff, state_in;
   logic [ACTION_W-1:0]   action_ff, action_in;
   logic [DATA_WIDTH-1:0] value_ff, value_in;
   logic [CNT_W-1:0]      count_ff, count_in;
   logic [CNT_W-1:0]      cursor_ff, cursor_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [STATUS_W-1:0]   status_ff, status_in;
   logic                  found_ff, found_in;
   logic [ITEM_W-1:0]     item_ff, item_in;
   logic [CNT_W-1:0]      length_ff, length_in;

   cell_ctl_type          ctl;
   logic [CNT_W-1:0]      cursor_eff;
   logic                  hit;
   logic [DATA_WIDTH-1:0] chain_item;
   logic                  accept;

   assign accept = (state_ff == ST_IDLE) && start;

   // wrap a cursor that sits at or past the end back to the first entry
   assign cursor_eff = (cursor_ff >= count_ff) ? '0 : cursor_ff;

   sal_chain #(
      .CAPACITY   (CAPACITY),
      .DATA_WIDTH (DATA_WIDTH),
      .CNT_W      (CNT_W)
   ) u_chain (
      .clock  (clock),
      .ctl    (ctl),
      .value  (value_ff),
      .count  (count_ff),
      .cursor (cursor_eff),
      .hit    (hit),
      .item   (chain_item)
   );

   // sequence the passes and work out the result of the action
   always_comb begin
      state_in     = state_ff;
      action_in    = action_ff;
      value_in     = value_ff;
      count_in     = count_ff;
      cursor_in    = cursor_ff;
      rsp_valid_in = 1'b0;
      status_in    = status_ff;
      found_in     = found_ff;
      item_in      = item_ff;
      length_in    = length_ff;
      ctl          = '0;

      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               action_in = req_action;
               value_in  = DATA_WIDTH'(req_value[VW-1:0]);
               state_in  = ST_COMPARE;
            end
         end
         ST_COMPARE: begin
            ctl.do_compare = 1'b1;
            state_in       = ST_UPDATE;
         end
         ST_UPDATE: begin
            status_in = STS_OK;
            found_in  = 1'b0;
            item_in   = '0;
            case (action_ff)
               ACT_INSERT: begin
                  if (count_ff == CAP_CNT) begin
                     status_in = STS_FULL;
                  end else begin
                     ctl.do_insert = 1'b1;
                     count_in      = CNT_W'(count_ff + 1'b1);
                  end
               end
               ACT_DELETE: begin
                  if (!hit) begin
                     status_in = STS_NOT_FOUND;
                  end else begin
                     ctl.do_remove = 1'b1;
                     count_in      = CNT_W'(count_ff - 1'b1);
                     cursor_in     = '0;
                  end
               end
               ACT_SEARCH: begin
                  found_in = hit;
               end
               ACT_GET_NEXT: begin
                  if (count_ff == '0) begin
                     status_in = STS_EMPTY;
                  end else begin
                     item_in   = ITEM_W'(chain_item[IW-1:0]);
                     cursor_in = CNT_W'(cursor_eff + 1'b1);
                  end
               end
               ACT_REWIND: begin
                  cursor_in = '0;
               end
               ACT_CLEAR: begin
                  count_in  = '0;
                  cursor_in = '0;
               end
               default: begin
               end
            endcase
            length_in    = count_in;
            rsp_valid_in = 1'b1;
            state_in     = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // hold state and registered results
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         cursor_ff    <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         cursor_ff    <= cursor_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      action_ff <= action_in;
      value_ff  <= value_in;
      status_ff <= status_in;
      found_ff  <= found_in;
      item_ff   <= item_in;
      length_ff <= length_in;
   end

   assign busy          = (state_ff != ST_IDLE);
   assign rsp_valid     = rsp_valid_ff;
   assign rsp_status    = status_ff;
   assign rsp_found     = found_ff;
   assign rsp_item      = item_ff;
   assign rsp_length    = LENGTH_W'(length_ff);
   assign rsp_full_res  = (length_ff == CAP_CNT);
   assign rsp_empty_res = (length_ff == '0);

endmodule

// ===== design/sal_cell.sv =====
// One storage cell of the sorted array list row: holds one entry and its compare flags.
// Depends on sal_pkg.
module sal_cell #(
   parameter int CAPACITY   = 16,
   parameter int DATA_WIDTH = 32,
   parameter int INDEX      = 0,
   parameter int CNT_W      = $clog2(CAPACITY + 1)
) (
   input  logic                  clock,
   input  sal_pkg::cell_ctl_type ctl,
   input  logic [DATA_WIDTH-1:0] value,
   input  logic [CNT_W-1:0]      count,
   input  logic [CNT_W-1:0]      cursor,
   input  logic [DATA_WIDTH-1:0] left_entry,
   input  logic                  left_lt,
   input  logic [DATA_WIDTH-1:0] right_entry,
   output logic [DATA_WIDTH-1:0] entry,
   output logic                  lt,
   output logic                  eq,
   output logic                  sel
);
   import sal_pkg::*;

   localparam logic [CNT_W-1:0] IDX = CNT_W'(INDEX);

   logic [DATA_WIDTH-1:0] entry_ff, entry_in;
   logic                  lt_ff, lt_in;
   logic                  eq_ff, eq_in;
   logic                  sel_ff, sel_in;
   logic                  in_range;

   // compare pass: flag entries below the operand, equal to it, or under the cursor
   always_comb begin
      in_range = (IDX < count);
      lt_in    = lt_ff;
      eq_in    = eq_ff;
      sel_in   = sel_ff;
      if (ctl.do_compare) begin
         lt_in  = in_range && (entry_ff < value);
         eq_in  = in_range && (entry_ff == value);
         sel_in = (IDX == cursor);
      end
   end

   // update pass: shift right on insert, shift left on remove, hold otherwise
   always_comb begin
      entry_in = entry_ff;
      if (ctl.do_insert && !lt_ff) begin
         entry_in = left_lt ? value : left_entry;
      end else if (ctl.do_remove && !lt_ff) begin
         entry_in = right_entry;
      end
   end

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
      lt_ff    <= lt_in;
      eq_ff    <= eq_in;
      sel_ff   <= sel_in;
   end

   assign entry = entry_ff;
   assign lt    = lt_ff;
   assign eq    = eq_ff;
   assign sel   = sel_ff;

endmodule

// ===== design/sal_chain.sv =====
// Row of sal_cell instances linked to their neighbors, plus the hit and read-out buses.
// Depends on sal_pkg and sal_cell.
module sal_chain #(
   parameter int CAPACITY   = 16,
   parameter int DATA_WIDTH = 32,
   parameter int CNT_W      = $clog2(CAPACITY + 1)
) (
   input  logic                  clock,
   input  sal_pkg::cell_ctl_type ctl,
   input  logic [DATA_WIDTH-1:0] value,
   input  logic [CNT_W-1:0]      count,
   input  logic [CNT_W-1:0]      cursor,
   output logic                  hit,
   output logic [DATA_WIDTH-1:0] item
);
   import sal_pkg::*;

   logic [DATA_WIDTH-1:0] entry_w [CAPACITY];
   logic [CAPACITY-1:0]   lt_w;
   logic [CAPACITY-1:0]   eq_w;
   logic [CAPACITY-1:0]   sel_w;

   // build the row; the head cell sees a "smaller" left neighbor, the tail keeps itself
   for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
      logic [DATA_WIDTH-1:0] left_entry;
      logic                  left_lt;
      logic [DATA_WIDTH-1:0] right_entry;

      if (g == 0) begin : g_head
         assign left_entry = value;
         assign left_lt    = 1'b1;
      end else begin : g_body
         assign left_entry = entry_w[g-1];
         assign left_lt    = lt_w[g-1];
      end

      if (g == CAPACITY - 1) begin : g_tail
         assign right_entry = entry_w[g];
      end else begin : g_next
         assign right_entry = entry_w[g+1];
      end

      sal_cell #(
         .CAPACITY   (CAPACITY),
         .DATA_WIDTH (DATA_WIDTH),
         .INDEX      (g),
         .CNT_W      (CNT_W)
      ) u_cell (
         .clock       (clock),
         .ctl         (ctl),
         .value       (value),
         .count       (count),
         .cursor      (cursor),
         .left_entry  (left_entry),
         .left_lt     (left_lt),
         .right_entry (right_entry),
         .entry       (entry_w[g]),
         .lt          (lt_w[g]),
         .eq          (eq_w[g]),
         .sel         (sel_w[g])
      );
   end

   // any stored equal entry counts as a hit
   assign hit = |eq_w;

   // at most one cell is selected by the cursor; merge onto a wired-or bus
   always_comb begin
      item = '0;
      for (int i = 0; i < CAPACITY; i++) begin
         if (sel_w[i]) begin
            item = item | entry_w[i];
         end
      end
   end

endmodule

// ===== design/sal_checker.sv =====
// Port-level checks for sorted_array_list_unit and the bind that attaches them.
// Depends on sal_pkg.
module sal_checker (
   input logic                          clock,
   input logic                          reset,
   input logic                          start,
   input logic                          busy,
   input logic [sal_pkg::ACTION_W-1:0]  req_action,
   input logic [sal_pkg::VALUE_W-1:0]   req_value,
   input logic                          rsp_valid,
   input logic [sal_pkg::STATUS_W-1:0]  rsp_status,
   input logic                          rsp_found,
   input logic [sal_pkg::ITEM_W-1:0]    rsp_item,
   input logic [sal_pkg::LENGTH_W-1:0]  rsp_length,
   input logic                          rsp_full_res,
   input logic                          rsp_empty_res
);
   import sal_pkg::*;

   // every accepted item yields its result on rsp_valid
   a_result_latency: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |-> ##3 rsp_valid)
      else $error("accepted item gave no result three cycles later");

   // empty flag tracks the reported length
   a_empty_length: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_empty_res == (rsp_length == '0)))
      else $error("empty flag disagrees with length");

   // a list cannot be full and empty at once
   a_full_empty: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !(rsp_full_res && rsp_empty_res))
      else $error("full and empty both set");

   // failing actions return neither an entry nor a hit
   a_fail_clean: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_status != STS_OK)) |-> ((rsp_item == '0) && !rsp_found))
      else $error("failed action returned data");

endmodule

bind sorted_array_list_unit sal_checker u_sal_checker (.*);
